FILE: design/rpmi_pkg.sv
// shared types, codes and arithmetic helpers of the motion integrator
package rpmi_pkg;

    localparam int C_WORD = 32;
    localparam int C_FRAC = 16;

    localparam logic [2:0] C_OP_TICK  = 3'd0;
    localparam logic [2:0] C_OP_ACCEL = 3'd1;
    localparam logic [2:0] C_OP_COLL  = 3'd2;
    localparam logic [2:0] C_OP_SETV  = 3'd3;
    localparam logic [2:0] C_OP_ADDV  = 3'd4;

    localparam logic [2:0] C_REG_THRESH = 3'd0;
    localparam logic [2:0] C_REG_ELAST  = 3'd1;
    localparam logic [2:0] C_REG_FRIC   = 3'd2;
    localparam logic [2:0] C_REG_TERM   = 3'd3;
    localparam logic [2:0] C_REG_BOUNCY = 3'd4;
    localparam logic [2:0] C_REG_EPS    = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_T_AM, S_T_AW, S_L2_M, S_L2_W, S_L2_END, S_T_TSM, S_T_TSW,
        S_SQRT, S_T_LM, S_T_LW, S_DIV, S_DIV_END, S_T_MVM, S_T_MVW,
        S_C_D1M, S_C_D1W, S_C_D2M, S_C_D2W, S_C_BM, S_C_BW, S_C_EM, S_C_EW,
        S_C_WM, S_C_WW, S_C_FM, S_C_FW, S_C_SM, S_C_SW, S_DONE
    } t_state;

    // signed saturation of a magnitude to the word range
    function automatic logic signed [31:0] f_sgn_sat(input logic neg, input logic [66:0] m);
        logic signed [31:0] res;
        if (neg) begin
            if (m > 67'h80000000) res = 32'sh80000000;
            else res = 32'(-m);
        end else begin
            if (m > 67'h7fffffff) res = 32'sh7fffffff;
            else res = m[31:0];
        end
        return res;
    endfunction

    // product magnitude shifted by 16 or 17 with round half away from zero
    function automatic logic signed [31:0] f_round(input logic [65:0] p, input logic neg,
                                                  input logic sh17);
        logic [66:0] t;
        logic [66:0] m;
        t = {1'b0, p} + (sh17 ? 67'd65536 : 67'd32768);
        m = sh17 ? (t >> 17) : (t >> 16);
        return f_sgn_sat(neg, m);
    endfunction

    function automatic logic signed [31:0] f_sat(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > 36'sh07fffffff) res = 32'sh7fffffff;
        else if (v < -36'sh080000000) res = 32'sh80000000;
        else res = v[31:0];
        return res;
    endfunction

endpackage

FILE: design/rigid_point_motion_integrator_top.sv
// motion integrator: sequencer around one shared multiplier, root and divide steps
//  channel | handshake               | payload
//  in      | i_in_valid / o_in_stall  | op, vec, eff, time_step
//  out     | o_out_valid / i_out_stall| move, bounced, speed
//  cfg     | i_cfg_we                | i_cfg_idx, i_cfg_data
// one beat at a time; each multiply goes through the shared multiplier and the product register
// tick: adds the root and three divides when the speed is capped; collision may add a root
// and one divide; other ops go straight to the output stage
// the root is 1 bit a cycle, the divide 1 quotient bit a cycle
// synchronous active-low reset clears velocity, acceleration and registers to defaults
// a result waits in the output register while stalled; the next beat is taken meanwhile
module rigid_point_motion_integrator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic signed [31:0] i_eff_x,
    input  logic signed [31:0] i_eff_y,
    input  logic signed [31:0] i_eff_z,
    input  logic [15:0]        i_time_step,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_move_valid,
    output logic signed [31:0] o_move_x,
    output logic signed [31:0] o_move_y,
    output logic signed [31:0] o_move_z,
    output logic               o_bounced,
    output logic signed [31:0] o_speed_x,
    output logic signed [31:0] o_speed_y,
    output logic signed [31:0] o_speed_z,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);

    rpmi_pkg::t_state r_state, n_state;

    logic [30:0] r_thresh;
    logic [16:0] r_elast;
    logic [24:0] r_fric;
    logic [30:0] r_term;
    logic        r_bouncy;
    logic [15:0] r_eps;

    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_acc [3];
    logic signed [31:0] r_nv  [3];
    logic signed [31:0] r_mv  [3];
    logic signed [31:0] r_n   [3];
    logic signed [31:0] r_e   [3];
    logic [15:0]        r_dt;
    logic [2:0]         r_op;
    logic [1:0]         r_idx;
    logic [5:0]         r_cnt;
    logic               r_pass;
    logic               r_mvalid;
    logic               r_bnc;
    logic [63:0]        r_sum;
    logic signed [34:0] r_dot;
    logic signed [31:0] r_y;
    logic [16:0]        r_fr;
    logic [65:0]        r_prod;
    logic               r_pneg;
    logic [63:0]        r_sx, r_sr, r_sbit;
    logic [63:0]        r_dq;
    logic [31:0]        r_drem;
    logic [31:0]        r_dden;

    logic               r_ovalid;
    logic               r_o_mvalid, r_o_bnc;
    logic signed [31:0] r_o_mv [3];
    logic signed [31:0] r_o_v  [3];

    logic signed [33:0] w_ma, w_mb;
    logic [32:0]        w_am, w_bm;
    logic [65:0]        w_p;
    logic signed [31:0] w_r16, w_r17;
    logic               w_last, w_tick, w_accept, w_load;
    logic signed [34:0] w_dnext;
    logic signed [31:0] w_y, w_dsat;
    logic signed [35:0] w_ndot;
    logic               w_bounce;
    logic signed [31:0] w_src;
    logic [63:0]        w_sadd;
    logic               w_sge;
    logic [32:0]        w_rsh;
    logic               w_dge;

    assign w_last   = (r_idx == 2'd2);
    assign w_tick   = (r_op == rpmi_pkg::C_OP_TICK);
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_load   = (r_state == rpmi_pkg::S_DONE) && (!r_ovalid || !i_out_stall);
    assign o_in_stall = (r_state != rpmi_pkg::S_IDLE);

    assign w_src = (w_tick && r_pass) ? r_mv[r_idx] : r_nv[r_idx];

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            rpmi_pkg::S_T_AM:  begin w_ma = 34'(r_acc[r_idx]); w_mb = {18'b0, r_dt}; end
            rpmi_pkg::S_L2_M:  begin w_ma = 34'(w_src); w_mb = 34'(w_src); end
            rpmi_pkg::S_T_TSM: begin w_ma = {3'b0, r_term}; w_mb = {3'b0, r_term}; end
            rpmi_pkg::S_T_LM:  begin w_ma = 34'(r_nv[r_idx]); w_mb = {3'b0, r_term}; end
            rpmi_pkg::S_T_MVM: begin
                w_ma = 34'(r_vel[r_idx]) + 34'(r_nv[r_idx]);
                w_mb = {18'b0, r_dt};
            end
            rpmi_pkg::S_C_D1M: begin w_ma = 34'(r_vel[r_idx]); w_mb = 34'(r_n[r_idx]); end
            rpmi_pkg::S_C_D2M: begin w_ma = 34'(r_e[r_idx]); w_mb = 34'(r_n[r_idx]); end
            rpmi_pkg::S_C_BM,
            rpmi_pkg::S_C_WM:  begin w_ma = 34'(r_y); w_mb = 34'(r_n[r_idx]); end
            rpmi_pkg::S_C_EM:  begin w_ma = 34'(r_nv[r_idx]); w_mb = {17'b0, r_elast}; end
            rpmi_pkg::S_C_FM:  begin w_ma = 34'(r_y); w_mb = {9'b0, r_fric}; end
            rpmi_pkg::S_C_SM:  begin w_ma = 34'(r_nv[r_idx]); w_mb = {17'b0, r_fr}; end
            default: ;
        endcase
    end

    assign w_am = w_ma[33] ? 33'(-w_ma) : w_ma[32:0];
    assign w_bm = w_mb[33] ? 33'(-w_mb) : w_mb[32:0];
    assign w_p  = w_am * w_bm;

    assign w_r16 = rpmi_pkg::f_round(r_prod, r_pneg, 1'b0);
    assign w_r17 = rpmi_pkg::f_round(r_prod, r_pneg, 1'b1);

    assign w_dnext  = r_dot + 35'(w_r16);
    assign w_dsat   = rpmi_pkg::f_sat(36'(w_dnext));
    assign w_y      = rpmi_pkg::f_sat(-36'(w_dnext));
    assign w_ndot   = -36'(w_dsat);
    assign w_bounce = r_bouncy && (w_ndot >= $signed({5'b0, r_thresh}));

    assign w_sadd = r_sr + r_sbit;
    assign w_sge  = (r_sx >= w_sadd);
    assign w_rsh  = {r_drem, r_dq[63]};
    assign w_dge  = (w_rsh >= {1'b0, r_dden});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpmi_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_op == rpmi_pkg::C_OP_TICK) n_state = rpmi_pkg::S_T_AM;
                    else if (i_op == rpmi_pkg::C_OP_COLL) n_state = rpmi_pkg::S_C_D1M;
                    else n_state = rpmi_pkg::S_DONE;
                end
            end
            rpmi_pkg::S_T_AM:  n_state = rpmi_pkg::S_T_AW;
            rpmi_pkg::S_T_AW:  n_state = w_last ? rpmi_pkg::S_L2_M : rpmi_pkg::S_T_AM;
            rpmi_pkg::S_L2_M:  n_state = rpmi_pkg::S_L2_W;
            rpmi_pkg::S_L2_W:  n_state = w_last ? rpmi_pkg::S_L2_END : rpmi_pkg::S_L2_M;
            rpmi_pkg::S_L2_END: begin
                if (w_tick) n_state = r_pass ? rpmi_pkg::S_DONE : rpmi_pkg::S_T_TSM;
                else if (r_sum <= 64'(r_eps)) n_state = rpmi_pkg::S_DONE;
                else n_state = rpmi_pkg::S_SQRT;
            end
            rpmi_pkg::S_T_TSM: n_state = rpmi_pkg::S_T_TSW;
            rpmi_pkg::S_T_TSW: begin
                // squared speed was kept in r_sx when the sum was cleared
                n_state = (r_sx > r_prod[63:0]) ? rpmi_pkg::S_SQRT : rpmi_pkg::S_T_MVM;
            end
            rpmi_pkg::S_SQRT: begin
                if (r_cnt == 6'd31) n_state = w_tick ? rpmi_pkg::S_T_LM : rpmi_pkg::S_C_FM;
            end
            rpmi_pkg::S_T_LM:  n_state = rpmi_pkg::S_T_LW;
            rpmi_pkg::S_T_LW:  n_state = rpmi_pkg::S_DIV;
            rpmi_pkg::S_DIV:   if (r_cnt == 6'd63) n_state = rpmi_pkg::S_DIV_END;
            rpmi_pkg::S_DIV_END: begin
                if (w_tick) n_state = w_last ? rpmi_pkg::S_T_MVM : rpmi_pkg::S_T_LM;
                else if (r_dq >= 64'd65536) n_state = rpmi_pkg::S_DONE;
                else n_state = rpmi_pkg::S_C_SM;
            end
            rpmi_pkg::S_T_MVM: n_state = rpmi_pkg::S_T_MVW;
            rpmi_pkg::S_T_MVW: n_state = w_last ? rpmi_pkg::S_L2_M : rpmi_pkg::S_T_MVM;
            rpmi_pkg::S_C_D1M: n_state = rpmi_pkg::S_C_D1W;
            rpmi_pkg::S_C_D1W: begin
                if (!w_last) n_state = rpmi_pkg::S_C_D1M;
                else if (w_y <= 32'sd0) n_state = rpmi_pkg::S_DONE;
                else n_state = rpmi_pkg::S_C_D2M;
            end
            rpmi_pkg::S_C_D2M: n_state = rpmi_pkg::S_C_D2W;
            rpmi_pkg::S_C_D2W: begin
                if (!w_last) n_state = rpmi_pkg::S_C_D2M;
                else n_state = w_bounce ? rpmi_pkg::S_C_BM : rpmi_pkg::S_C_WM;
            end
            rpmi_pkg::S_C_BM:  n_state = rpmi_pkg::S_C_BW;
            rpmi_pkg::S_C_BW:  n_state = rpmi_pkg::S_C_EM;
            rpmi_pkg::S_C_EM:  n_state = rpmi_pkg::S_C_EW;
            rpmi_pkg::S_C_EW:  n_state = w_last ? rpmi_pkg::S_DONE : rpmi_pkg::S_C_BM;
            rpmi_pkg::S_C_WM:  n_state = rpmi_pkg::S_C_WW;
            rpmi_pkg::S_C_WW:  n_state = w_last ? rpmi_pkg::S_L2_M : rpmi_pkg::S_C_WM;
            rpmi_pkg::S_C_FM:  n_state = rpmi_pkg::S_C_FW;
            rpmi_pkg::S_C_FW:  n_state = rpmi_pkg::S_DIV;
            rpmi_pkg::S_C_SM:  n_state = rpmi_pkg::S_C_SW;
            rpmi_pkg::S_C_SW:  n_state = w_last ? rpmi_pkg::S_DONE : rpmi_pkg::S_C_SM;
            rpmi_pkg::S_DONE:  if (w_load) n_state = rpmi_pkg::S_IDLE;
            default: n_state = rpmi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= rpmi_pkg::S_IDLE;
        else r_state <= n_state;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 31'd65536;
            r_elast  <= 17'd32768;
            r_fric   <= 25'd19661;
            r_term   <= 31'd3276800;
            r_bouncy <= 1'b0;
            r_eps    <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rpmi_pkg::C_REG_THRESH: r_thresh <= i_cfg_data;
                rpmi_pkg::C_REG_ELAST:  r_elast  <= i_cfg_data[16:0];
                rpmi_pkg::C_REG_FRIC:   r_fric   <= i_cfg_data[24:0];
                rpmi_pkg::C_REG_TERM:   r_term   <= i_cfg_data;
                rpmi_pkg::C_REG_BOUNCY: r_bouncy <= i_cfg_data[0];
                rpmi_pkg::C_REG_EPS:    r_eps    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // payload registers of the datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_p;
        r_pneg <= w_ma[33] ^ w_mb[33];
        unique case (r_state)
            rpmi_pkg::S_IDLE: begin
                r_op   <= i_op;
                r_n[0] <= i_vec_x; r_n[1] <= i_vec_y; r_n[2] <= i_vec_z;
                r_e[0] <= i_eff_x; r_e[1] <= i_eff_y; r_e[2] <= i_eff_z;
                r_dt   <= i_time_step;
                r_sum  <= '0;
                r_dot  <= '0;
                for (int i = 0; i < 3; i++) r_mv[i] <= '0;
            end
            rpmi_pkg::S_T_AW: begin
                r_nv[r_idx] <= rpmi_pkg::f_sat(36'(r_vel[r_idx]) + 36'(w_r16));
            end
            rpmi_pkg::S_L2_W: r_sum <= r_sum + r_prod[63:0];
            rpmi_pkg::S_L2_END: begin
                r_sx   <= r_sum;
                r_sr   <= '0;
                r_sbit <= 64'h4000000000000000;
                r_sum  <= '0;
                if (w_tick && r_pass && r_sum <= 64'(r_eps))
                    for (int i = 0; i < 3; i++) r_mv[i] <= '0;
            end
            rpmi_pkg::S_SQRT: begin
                if (w_sge) begin
                    r_sx <= r_sx - w_sadd;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            rpmi_pkg::S_T_LW, rpmi_pkg::S_C_FW: begin
                r_dq   <= r_prod[63:0];
                r_drem <= '0;
                r_dden <= r_sr[31:0];
            end
            rpmi_pkg::S_DIV: begin
                r_drem <= w_dge ? 32'(w_rsh - {1'b0, r_dden}) : w_rsh[31:0];
                r_dq   <= {r_dq[62:0], w_dge};
            end
            rpmi_pkg::S_DIV_END: begin
                if (w_tick) r_nv[r_idx] <= rpmi_pkg::f_sgn_sat(r_nv[r_idx][31], {3'b0, r_dq});
                else r_fr <= 17'(17'h10000 - {1'b0, r_dq[15:0]});
            end
            rpmi_pkg::S_T_MVW: r_mv[r_idx] <= w_r17;
            rpmi_pkg::S_C_D1W: begin
                r_dot <= w_last ? 35'sd0 : w_dnext;
                r_y   <= w_y;
            end
            rpmi_pkg::S_C_D2W: r_dot <= w_dnext;
            rpmi_pkg::S_C_BW: begin
                r_nv[r_idx] <= rpmi_pkg::f_sat(36'(r_vel[r_idx]) + (36'(w_r16) <<< 1));
            end
            rpmi_pkg::S_C_WW: begin
                r_nv[r_idx] <= rpmi_pkg::f_sat(36'(r_vel[r_idx]) + 36'(w_r16));
            end
            default: ;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_vel[i] <= '0;
                r_acc[i] <= '0;
            end
            r_idx    <= '0;
            r_cnt    <= '0;
            r_pass   <= 1'b0;
            r_mvalid <= 1'b0;
            r_bnc    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                rpmi_pkg::S_IDLE: begin
                    r_idx    <= '0;
                    r_pass   <= 1'b0;
                    r_mvalid <= 1'b0;
                    r_bnc    <= 1'b0;
                    if (w_accept) begin
                        unique case (i_op)
                            rpmi_pkg::C_OP_ACCEL: begin
                                r_acc[0] <= rpmi_pkg::f_sat(36'(r_acc[0]) + 36'(i_vec_x));
                                r_acc[1] <= rpmi_pkg::f_sat(36'(r_acc[1]) + 36'(i_vec_y));
                                r_acc[2] <= rpmi_pkg::f_sat(36'(r_acc[2]) + 36'(i_vec_z));
                            end
                            rpmi_pkg::C_OP_SETV: begin
                                r_vel[0] <= i_vec_x;
                                r_vel[1] <= i_vec_y;
                                r_vel[2] <= i_vec_z;
                            end
                            rpmi_pkg::C_OP_ADDV: begin
                                r_vel[0] <= rpmi_pkg::f_sat(36'(r_vel[0]) + 36'(i_vec_x));
                                r_vel[1] <= rpmi_pkg::f_sat(36'(r_vel[1]) + 36'(i_vec_y));
                                r_vel[2] <= rpmi_pkg::f_sat(36'(r_vel[2]) + 36'(i_vec_z));
                            end
                            default: ;
                        endcase
                    end
                end
                rpmi_pkg::S_T_AW, rpmi_pkg::S_L2_W, rpmi_pkg::S_T_MVW, rpmi_pkg::S_C_D1W,
                rpmi_pkg::S_C_D2W, rpmi_pkg::S_C_WW, rpmi_pkg::S_C_EW: begin
                    r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
                    if (r_state == rpmi_pkg::S_T_MVW && w_last) r_pass <= 1'b1;
                    if (r_state == rpmi_pkg::S_C_EW) begin
                        r_vel[r_idx] <= w_r16;
                        r_bnc        <= 1'b1;
                    end
                end
                rpmi_pkg::S_C_SW: begin
                    r_vel[r_idx] <= w_r16;
                    r_idx        <= w_last ? 2'd0 : r_idx + 2'd1;
                end
                rpmi_pkg::S_T_TSW: begin
                    r_idx <= '0;
                    r_cnt <= '0;
                end
                rpmi_pkg::S_L2_END: begin
                    r_cnt <= '0;
                    if (w_tick && r_pass) begin
                        r_mvalid <= (r_sum > 64'(r_eps));
                        for (int i = 0; i < 3; i++) begin
                            r_vel[i] <= r_nv[i];
                            r_acc[i] <= '0;
                        end
                    end else if (!w_tick && r_sum <= 64'(r_eps)) begin
                        for (int i = 0; i < 3; i++) r_vel[i] <= '0;
                    end
                end
                rpmi_pkg::S_SQRT, rpmi_pkg::S_DIV: r_cnt <= r_cnt + 6'd1;
                rpmi_pkg::S_T_LW, rpmi_pkg::S_C_FW: r_cnt <= '0;
                rpmi_pkg::S_DIV_END: begin
                    if (w_tick) r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
                    else if (r_dq >= 64'd65536) for (int i = 0; i < 3; i++) r_vel[i] <= '0;
                end
                rpmi_pkg::S_DONE: begin
                    if (w_load) r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_mvalid <= r_mvalid;
            r_o_bnc    <= r_bnc;
            for (int i = 0; i < 3; i++) begin
                r_o_mv[i] <= r_mv[i];
                r_o_v[i]  <= r_vel[i];
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_move_valid = r_o_mvalid;
    assign o_move_x     = r_o_mv[0];
    assign o_move_y     = r_o_mv[1];
    assign o_move_z     = r_o_mv[2];
    assign o_bounced    = r_o_bnc;
    assign o_speed_x    = r_o_v[0];
    assign o_speed_y    = r_o_v[1];
    assign o_speed_z    = r_o_v[2];

    // a move and a bounce never come from one beat
    a_move_xor_bounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_move_valid && o_bounced))
        else $error("move and bounce flagged together");

    // a zero move carries zero fields
    a_zero_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_move_valid) |->
        (o_move_x == 32'sd0 && o_move_y == 32'sd0 && o_move_z == 32'sd0))
        else $error("nonzero move without move_valid");

    // an accepted beat keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after accept");

endmodule

FILE: tb/tb.sv
// testbench for the motion integrator: directed and random events checked against a predictor
`timescale 1ns / 1ps
module tb;

    typedef struct packed {
        logic               mv_ok;
        logic signed [31:0] mx, my, mz;
        logic               bnc;
        logic signed [31:0] sx, sy, sz;
    } t_result;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int WDOG_LIMIT = 20000;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [2:0] op;
    logic signed [31:0] vx, vy, vz, ex, ey, ez;
    logic [15:0] dt;
    logic cfg_we;
    logic [2:0] cfg_idx;
    logic [30:0] cfg_data;
    t_result got;

    // predictor state and register copies
    longint body_vel[3], accel_sum[3];
    longint unsigned r_thresh, r_elast, r_fric, r_term, r_bouncy, r_eps;

    t_result motion_q[$];
    int mismatches = 0;
    int idle_cnt = 0;
    int hold_req = 0;
    bit quiet = 0;

    rigid_point_motion_integrator_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_op(op), .i_vec_x(vx), .i_vec_y(vy), .i_vec_z(vz),
        .i_eff_x(ex), .i_eff_y(ey), .i_eff_z(ez), .i_time_step(dt),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_move_valid(got.mv_ok), .o_move_x(got.mx), .o_move_y(got.my), .o_move_z(got.mz),
        .o_bounced(got.bnc), .o_speed_x(got.sx), .o_speed_y(got.sy), .o_speed_z(got.sz),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        clk = 1'b1; #6;
        clk = 1'b0; #6;
    end

    // ---------------- fixed point arithmetic of the predictor ----------------
    function automatic longint sat_w(input longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint unsigned magn(input longint a);
        return (a < 0) ? longint'(0) - a : a;
    endfunction

    function automatic longint sat_mag(input bit neg, input logic [127:0] m);
        if (neg) return (m > 128'h80000000) ? WMIN : -longint'(m[63:0]);
        return (m > 128'h7fffffff) ? WMAX : longint'(m[63:0]);
    endfunction

    // product shifted right with round half away from zero
    function automatic longint mul_round(input longint a, input longint b, input int sh);
        logic [127:0] p;
        p = magn(a) * magn(b);
        p = (p + (128'd1 << (sh - 1))) >> sh;
        return sat_mag((a < 0) != (b < 0), p);
    endfunction

    function automatic longint unsigned sq_len(input longint v[3]);
        longint unsigned s;
        s = 0;
        for (int i = 0; i < 3; i++) s += magn(v[i]) * magn(v[i]);
        return s;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint scale_div(input longint a, input longint unsigned b,
                                         input longint unsigned d);
        logic [127:0] p;
        p = magn(a) * b;
        return sat_mag(a < 0, p / d);
    endfunction

    function automatic longint dot3(input longint a[3], input longint b[3]);
        longint s;
        s = 0;
        for (int i = 0; i < 3; i++) s += mul_round(a[i], b[i], rpmi_pkg::C_FRAC);
        return sat_w(s);
    endfunction

    function automatic t_result predict_motion(input logic [2:0] o, input longint v[3],
                                               input longint e[3], input longint unsigned ts);
        t_result res;
        longint nv[3], mv[3], w[3];
        longint unsigned s2, s, x2, x, f;
        longint y;
        res = '0;
        mv = '{0, 0, 0};
        case (o)
            rpmi_pkg::C_OP_TICK: begin
                for (int i = 0; i < 3; i++)
                    nv[i] = sat_w(body_vel[i] + mul_round(accel_sum[i], ts, 16));
                s2 = sq_len(nv);
                if (s2 > r_term * r_term) begin
                    s = floor_root(s2);
                    if (s == 0) s = 1;
                    for (int i = 0; i < 3; i++) nv[i] = scale_div(nv[i], r_term, s);
                end
                for (int i = 0; i < 3; i++) mv[i] = mul_round(body_vel[i] + nv[i], ts, 17);
                res.mv_ok = sq_len(mv) > r_eps;
                if (!res.mv_ok) mv = '{0, 0, 0};
                for (int i = 0; i < 3; i++) begin
                    body_vel[i] = nv[i];
                    accel_sum[i] = 0;
                end
            end
            rpmi_pkg::C_OP_ACCEL:
                for (int i = 0; i < 3; i++) accel_sum[i] = sat_w(accel_sum[i] + v[i]);
            rpmi_pkg::C_OP_COLL: begin
                y = sat_w(-dot3(body_vel, v));
                if (y > 0) begin
                    if (r_bouncy != 0 && -dot3(e, v) >= longint'(r_thresh)) begin
                        for (int i = 0; i < 3; i++)
                            body_vel[i] = mul_round(
                                sat_w(body_vel[i] + 2 * mul_round(y, v[i], rpmi_pkg::C_FRAC)),
                                r_elast, 16);
                        res.bnc = 1'b1;
                    end else begin
                        for (int i = 0; i < 3; i++)
                            w[i] = sat_w(body_vel[i] + mul_round(y, v[i], rpmi_pkg::C_FRAC));
                        x2 = sq_len(w);
                        if (x2 <= r_eps) begin
                            body_vel = '{0, 0, 0};
                        end else begin
                            x = floor_root(x2);
                            if (x == 0) x = 1;
                            f = longint'(y) * r_fric / x;
                            if (f >= 65536) body_vel = '{0, 0, 0};
                            else for (int i = 0; i < 3; i++)
                                body_vel[i] = mul_round(w[i], 65536 - f, 16);
                        end
                    end
                end
            end
            rpmi_pkg::C_OP_SETV: for (int i = 0; i < 3; i++) body_vel[i] = v[i];
            rpmi_pkg::C_OP_ADDV:
                for (int i = 0; i < 3; i++) body_vel[i] = sat_w(body_vel[i] + v[i]);
            default: ;
        endcase
        res.mx = mv[0];
        res.my = mv[1];
        res.mz = mv[2];
        res.sx = body_vel[0];
        res.sy = body_vel[1];
        res.sz = body_vel[2];
        return res;
    endfunction

    // ---------------- drivers ----------------
    task automatic send_event(input logic [2:0] o, input longint v[3], input longint e[3],
                              input logic [15:0] ts);
        if (!quiet && $urandom_range(99) < 7) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
        end else begin
            @(negedge clk);
        end
        in_valid = 1'b1;
        op = o;
        vx = v[0]; vy = v[1]; vz = v[2];
        ex = e[0]; ey = e[1]; ez = e[2];
        dt = ts;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        motion_q.push_back(predict_motion(o, v, e, ts));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (motion_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint unsigned val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val[30:0];
        case (idx)
            rpmi_pkg::C_REG_THRESH: r_thresh = val & 64'h7fffffff;
            rpmi_pkg::C_REG_ELAST:  r_elast  = val & 64'h1ffff;
            rpmi_pkg::C_REG_FRIC:   r_fric   = val & 64'h1ffffff;
            rpmi_pkg::C_REG_TERM:   r_term   = val & 64'h7fffffff;
            rpmi_pkg::C_REG_BOUNCY: r_bouncy = val & 64'h1;
            rpmi_pkg::C_REG_EPS:    r_eps    = val & 64'hffff;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic longint rand_comp();
        case ($urandom_range(5))
            0: return longint'($signed($urandom()));
            1: return $urandom_range(1) ? WMAX : WMIN;
            2: return 0;
            default: return longint'($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    function automatic void rand_unit(output longint n[3]);
        int ax;
        longint m;
        ax = $urandom_range(2);
        m = $urandom_range(1) ? 65536 : -65536;
        n = '{0, 0, 0};
        case ($urandom_range(3))
            0: begin
                n[ax] = 46341 * (m / 65536);
                n[(ax + 1) % 3] = $urandom_range(1) ? 46341 : -46341;
            end
            1: for (int i = 0; i < 3; i++) n[i] = rand_comp();
            default: n[ax] = m;
        endcase
    endfunction

    task automatic send_random();
        longint v[3], e[3];
        logic [2:0] o;
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) o = rpmi_pkg::C_OP_TICK;
        else if (pick < 45) o = rpmi_pkg::C_OP_ACCEL;
        else if (pick < 70) o = rpmi_pkg::C_OP_COLL;
        else if (pick < 82) o = rpmi_pkg::C_OP_SETV;
        else if (pick < 95) o = rpmi_pkg::C_OP_ADDV;
        else o = 3'($urandom_range(7, 5));
        for (int i = 0; i < 3; i++) begin
            v[i] = rand_comp();
            e[i] = rand_comp();
        end
        if (o == rpmi_pkg::C_OP_COLL) begin
            rand_unit(v);
            // effective velocity set to the body velocity about half the time so bounce tests are meaningful
            if ($urandom_range(1)) e = body_vel;
        end
        send_event(o, v, e, 16'($urandom()));
    endtask

    // ---------------- receiver and checker ----------------
    always @(negedge clk) begin
        if (hold_req > 0) begin
            out_stall <= 1'b1;
            hold_req <= hold_req - 1;
        end else if (quiet) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 7);
        end
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (motion_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = motion_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        longint z[3], up[3];
        z = '{0, 0, 0};
        up = '{0, 65536, 0};
        send_event(rpmi_pkg::C_OP_SETV, '{WMAX, WMIN, 0}, z, 0);
        send_event(rpmi_pkg::C_OP_ADDV, '{WMAX, WMIN, -1}, z, 0);
        send_event(rpmi_pkg::C_OP_TICK, z, z, 16'hffff);          // capped at terminal speed
        send_event(rpmi_pkg::C_OP_ACCEL, '{WMAX, WMAX, WMIN}, z, 0);
        send_event(rpmi_pkg::C_OP_ACCEL, '{WMAX, 5, WMIN}, z, 0);
        send_event(rpmi_pkg::C_OP_TICK, z, z, 16'hffff);
        send_event(rpmi_pkg::C_OP_SETV, '{65536, -131072, 0}, z, 0);
        send_event(rpmi_pkg::C_OP_TICK, z, z, 0);                 // zero move
        send_event(rpmi_pkg::C_OP_TICK, z, z, 1);
        send_event(rpmi_pkg::C_OP_COLL, up, z, 0);                // moving into the surface, friction slows the slide
        send_event(rpmi_pkg::C_OP_SETV, '{0, -131072, 0}, z, 0);
        send_event(rpmi_pkg::C_OP_COLL, up, z, 0);                // sliding speed zero
        send_event(rpmi_pkg::C_OP_SETV, '{65536, -655360, 0}, z, 0);
        send_event(rpmi_pkg::C_OP_COLL, up, z, 0);                // friction stops the body
        send_event(rpmi_pkg::C_OP_SETV, '{6553600, -65536, 0}, z, 0);
        send_event(rpmi_pkg::C_OP_COLL, up, z, 0);                // friction slows the body
        for (int u = 5; u < 8; u++)
            send_event(3'(u), '{WMIN, WMAX, -1}, '{WMAX, WMIN, 1}, 16'hffff);
        drain_results();
        write_reg(rpmi_pkg::C_REG_BOUNCY, 1);
        send_event(rpmi_pkg::C_OP_SETV, '{65536, -655360, 0}, z, 0);
        send_event(rpmi_pkg::C_OP_COLL, up, '{0, -655360, 0}, 0); // bounce
        send_event(rpmi_pkg::C_OP_SETV, '{65536, -655360, 0}, z, 0);
        send_event(rpmi_pkg::C_OP_COLL, up, '{0, -100, 0}, 0);    // too slow to bounce
        drain_results();
    endtask

    task automatic test_settings();
        longint unsigned setting[4][6];
        setting[0] = '{0, 0, 0, 0, 0, 0};
        setting[1] = '{64'h7fffffff, 65536, 16777216, 64'h7fffffff, 1, 65535};
        setting[2] = '{0, 65536, 0, 3276800, 1, 0};
        setting[3] = '{65536, 32768, 19661, 3276800, 0, 1};
        for (int k = 0; k < 5; k++) begin
            for (int r = 0; r < 6; r++) begin
                if (k < 4) write_reg(3'(r), setting[k][r]);
                else write_reg(3'(r), longint'($urandom()));
            end
            quiet = (k == 2);
            repeat (60) send_random();
            drain_results();
            quiet = 0;
        end
    endtask

    task automatic test_backpressure();
        hold_req = 400;
        repeat (20) send_random();
        drain_results();
    endtask

    task automatic test_random();
        for (int k = 0; k < 4; k++) begin
            write_reg(rpmi_pkg::C_REG_BOUNCY, $urandom_range(1));
            write_reg(rpmi_pkg::C_REG_EPS, $urandom_range(65535));
            write_reg(rpmi_pkg::C_REG_THRESH, $urandom_range(300000));
            write_reg(rpmi_pkg::C_REG_TERM, $urandom_range(20000000));
            repeat (40) send_random();
            drain_results();
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        op = '0;
        vx = '0; vy = '0; vz = '0;
        ex = '0; ey = '0; ez = '0;
        dt = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        body_vel = '{0, 0, 0};
        accel_sum = '{0, 0, 0};
        r_thresh = 65536;
        r_elast = 32768;
        r_fric = 19661;
        r_term = 3276800;
        r_bouncy = 0;
        r_eps = 1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_settings();
        test_backpressure();
        test_random();

        drain_results();
        repeat (300) @(posedge clk);
        if (mismatches == 0 && motion_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
